FILE: rtl/core/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, constants and fixed-point helpers of the piecewise polynomial
// pose evaluator.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int COEF_W   = 64;
  localparam int TIME_W   = 32;
  localparam int POS_W    = 32;
  localparam int YAW_W    = 16;
  localparam int ZACC_W   = 18;
  localparam int CORD_W   = 34;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int NORM_BIT = 29;

  localparam logic signed [ZACC_W-1:0] YAW_PI      = 18'sd25736;
  localparam logic signed [ZACC_W-1:0] YAW_HALF_PI = 18'sd12868;

  localparam logic signed [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_COEFF = 2'd0,
    REQ_BREAK = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_SEG_COUNT = 2'd0,
    REG_POLY_DEG  = 2'd1,
    REG_START_YAW = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]         segment_count;
    logic [2:0]         poly_degree;
    logic signed [15:0] start_yaw;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CO_RD,
    ST_CO_LD,
    ST_P_FIN,
    ST_P_ADD,
    ST_D_FIN,
    ST_D_ADD,
    ST_NEXT,
    ST_YAW,
    ST_RESULT
  } seq_state_t;

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_NORM,
    CD_ROT,
    CD_DONE
  } cordic_state_t;

  function automatic logic [COEF_W-1:0] mag64(input logic signed [COEF_W-1:0] v);
    mag64 = v[COEF_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [COEF_W-1:0] from_mag(input logic neg,
      input logic [COEF_W-1:0] m, input logic ovf);
    if (neg) begin
      from_mag = (ovf || m[COEF_W-1]) ? Q_MIN : (~m + 64'd1);
    end else begin
      from_mag = (ovf || m[COEF_W-1]) ? Q_MAX : m;
    end
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_add(input logic signed [COEF_W-1:0] a,
      input logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      sat_add = s[COEF_W] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[COEF_W-1:0];
    end
  endfunction

  // Multiply by a small integer (derivative weights).
  function automatic logic signed [COEF_W-1:0] mul_small(input logic signed [COEF_W-1:0] a,
      input logic [3:0] n);
    logic [COEF_W+3:0] p;
    p = {4'd0, mag64(a)} * {64'd0, n};
    mul_small = from_mag(a[COEF_W-1], p[COEF_W-1:0], |p[COEF_W+3:COEF_W]);
  endfunction

  // Combines the two registered partial products of a Q32.32 by Q12.20 multiply.
  function automatic logic signed [COEF_W-1:0] mul_time_fin(input logic neg,
      input logic [COEF_W-1:0] lo, input logic [COEF_W-1:0] hi);
    logic ovf;
    logic [COEF_W-1:0] r;
    ovf = |hi[63:51];
    r = (hi << 12) + (lo >> 20);
    mul_time_fin = from_mag(neg, ovf ? '0 : r, ovf);
  endfunction

  function automatic logic [POS_W-1:0] to_q16(input logic signed [COEF_W-1:0] v);
    logic [47:0] m;
    m = 48'(mag64(v) >> 16);
    if (v[COEF_W-1]) begin
      if (m > 48'h8000_0000) m = 48'h8000_0000;
      to_q16 = ~m[31:0] + 32'd1;
    end else begin
      if (m > 48'h7FFF_FFFF) m = 48'h7FFF_FFFF;
      to_q16 = m[31:0];
    end
  endfunction

  function automatic logic signed [ZACC_W-1:0] atan_tab(input logic [3:0] i);
    case (i)
      4'd0:    atan_tab = 18'sd6434;
      4'd1:    atan_tab = 18'sd3798;
      4'd2:    atan_tab = 18'sd2007;
      4'd3:    atan_tab = 18'sd1019;
      4'd4:    atan_tab = 18'sd511;
      4'd5:    atan_tab = 18'sd256;
      4'd6:    atan_tab = 18'sd128;
      4'd7:    atan_tab = 18'sd64;
      4'd8:    atan_tab = 18'sd32;
      4'd9:    atan_tab = 18'sd16;
      4'd10:   atan_tab = 18'sd8;
      4'd11:   atan_tab = 18'sd4;
      4'd12:   atan_tab = 18'sd2;
      4'd13:   atan_tab = 18'sd1;
      default: atan_tab = 18'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/ppe_if.sv
// ----------------------------------------------------------------------------
// ppe_if
// Valid/ready channels of the pose evaluator: request and result.
// ----------------------------------------------------------------------------
interface ppe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         axis;
  logic [4:0]         slot;
  logic [2:0]         coeff_index;
  logic signed [63:0] coeff_value;
  logic [31:0]        time_value;

  modport source (output valid, req_type, axis, slot, coeff_index, coeff_value,
                  time_value, input ready);
  modport sink (input valid, req_type, axis, slot, coeff_index, coeff_value,
                time_value, output ready);
endinterface

interface ppe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] heading;
  logic               found;

  modport source (output valid, pos_x, pos_y, pos_z, heading, found, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, heading, found, output ready);
endinterface

FILE: rtl/core/ppe_cfg.sv
// ----------------------------------------------------------------------------
// ppe_cfg
// APB-style configuration registers: segment count, degree and start yaw.
// ----------------------------------------------------------------------------
module ppe_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0]    paddr,
  input  logic [ppe_pkg::CFG_DW-1:0]    pwdata,
  output logic [ppe_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output ppe_pkg::cfg_t                 cfg
);

  ppe_pkg::cfg_t     cfg_r;
  ppe_pkg::reg_idx_t idx;

  assign idx    = ppe_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segment_count <= 5'd1;
      cfg_r.poly_degree   <= 3'd6;
      cfg_r.start_yaw     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ppe_pkg::REG_SEG_COUNT: cfg_r.segment_count <= pwdata[4:0];
        ppe_pkg::REG_POLY_DEG:  cfg_r.poly_degree   <= pwdata[2:0];
        ppe_pkg::REG_START_YAW: cfg_r.start_yaw     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppe_pkg::REG_SEG_COUNT: prdata = {27'd0, cfg_r.segment_count};
      ppe_pkg::REG_POLY_DEG:  prdata = {29'd0, cfg_r.poly_degree};
      ppe_pkg::REG_START_YAW: prdata = {16'd0, cfg_r.start_yaw};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/ppe_cordic.sv
// ----------------------------------------------------------------------------
// ppe_cordic
// Iterative atan2: normalizes one bit per cycle, then 16 vectoring steps; dy zero with dx <= 0 skips both.
// ----------------------------------------------------------------------------
module ppe_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ppe_pkg::COEF_W-1:0]    dx,
  input  logic signed [ppe_pkg::COEF_W-1:0]    dy,
  output logic                                 done,
  output logic signed [ppe_pkg::YAW_W-1:0]     heading
);

  localparam int W = ppe_pkg::CORD_W;

  ppe_pkg::cordic_state_t state_r, state_nxt;

  logic [ppe_pkg::COEF_W-1:0]         mx_r, my_r;
  logic                               sx_r, sy_r;
  logic signed [W-1:0]                xi_r, yi_r;
  logic signed [ppe_pkg::ZACC_W-1:0]  z_r;
  logic [3:0]                         step_r;
  logic                               big;
  logic signed [W-1:0]                xs, ys, sh_x, sh_y;
  logic signed [ppe_pkg::ZACC_W-1:0]  z_clamp;

  assign big  = |mx_r[63:ppe_pkg::NORM_BIT] || |my_r[63:ppe_pkg::NORM_BIT];
  assign xs   = sx_r ? -W'(mx_r[ppe_pkg::NORM_BIT-1:0]) : W'(mx_r[ppe_pkg::NORM_BIT-1:0]);
  assign ys   = sy_r ? -W'(my_r[ppe_pkg::NORM_BIT-1:0]) : W'(my_r[ppe_pkg::NORM_BIT-1:0]);
  assign sh_x = xi_r >>> step_r;
  assign sh_y = yi_r >>> step_r;

  always_comb begin
    if (z_r > ppe_pkg::YAW_PI) z_clamp = ppe_pkg::YAW_PI;
    else if (z_r < -ppe_pkg::YAW_PI) z_clamp = -ppe_pkg::YAW_PI;
    else z_clamp = z_r;
  end

  assign done    = (state_r == ppe_pkg::CD_DONE);
  assign heading = z_clamp[ppe_pkg::YAW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ppe_pkg::CD_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppe_pkg::CD_IDLE: begin
        if (start) begin
          if (dy == '0) state_nxt = (dx[63] || dx == '0) ? ppe_pkg::CD_DONE : ppe_pkg::CD_NORM;
          else          state_nxt = ppe_pkg::CD_NORM;
        end
      end
      ppe_pkg::CD_NORM: if (!big) state_nxt = ppe_pkg::CD_ROT;
      ppe_pkg::CD_ROT:  if (step_r == 4'(ppe_pkg::CORDIC_STEPS - 1)) state_nxt = ppe_pkg::CD_DONE;
      ppe_pkg::CD_DONE: state_nxt = ppe_pkg::CD_IDLE;
      default:          state_nxt = ppe_pkg::CD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ppe_pkg::CD_IDLE: begin
        mx_r   <= ppe_pkg::mag64(dx);
        my_r   <= ppe_pkg::mag64(dy);
        sx_r   <= dx[63];
        sy_r   <= dy[63];
        step_r <= '0;
        // Both zero gives zero; a negative x on the axis gives pi.
        z_r    <= (dy == '0 && dx[63]) ? ppe_pkg::YAW_PI : '0;
      end
      ppe_pkg::CD_NORM: begin
        if (big) begin
          mx_r <= mx_r >> 1;
          my_r <= my_r >> 1;
        end else if (xs < 0) begin
          if (ys >= 0) begin
            xi_r <= ys;
            yi_r <= -xs;
            z_r  <= ppe_pkg::YAW_HALF_PI;
          end else begin
            xi_r <= -ys;
            yi_r <= xs;
            z_r  <= -ppe_pkg::YAW_HALF_PI;
          end
        end else begin
          xi_r <= xs;
          yi_r <= ys;
          z_r  <= '0;
        end
      end
      ppe_pkg::CD_ROT: begin
        if (yi_r >= 0) begin
          xi_r <= xi_r + sh_y;
          yi_r <= yi_r - sh_x;
          z_r  <= z_r + ppe_pkg::atan_tab(step_r);
        end else begin
          xi_r <= xi_r - sh_y;
          yi_r <= yi_r + sh_x;
          z_r  <= z_r - ppe_pkg::atan_tab(step_r);
        end
        step_r <= step_r + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/piecewise_poly_pose_eval_top.sv
// ----------------------------------------------------------------------------
// piecewise_poly_pose_eval_top
// Piecewise polynomial pose evaluator: coefficient and breakpoint memories,
// segment search, Horner evaluation of position and slope, CORDIC heading.
//
//   channel   direction  handshake             payload
//   in_ch     sink       valid/ready           request, load or evaluate
//   out_ch    source     valid/ready           pos_x/y/z, heading, found
//   cfg       APB slave  psel/penable/pready   segment_count, degree, yaw
//
// A load transaction is written as it is accepted. An evaluate transaction has a
// breakpoint search, Horner evaluation (one 64x32 multiply split into two 32x32
// halves), CORDIC normalization and rotation unless the time is zero, and a
// result step; a zero segment count or a miss skips to the result.
// Reset is synchronous and clears control state only; the stores are
// undefined until written. A finished evaluation waits while the output is full.
// ----------------------------------------------------------------------------
module piecewise_poly_pose_eval_top #(
  parameter int MAX_SEGMENTS = 16,
  parameter int MAX_COEFFS   = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ppe_in_if.sink                      in_ch,
  ppe_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0]  paddr,
  input  logic [ppe_pkg::CFG_DW-1:0]  pwdata,
  output logic [ppe_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int CDEPTH = 3 * MAX_SEGMENTS * MAX_COEFFS;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int BDEPTH = MAX_SEGMENTS + 1;
  localparam int BP_W   = $clog2(BDEPTH);
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int K_W    = $clog2(MAX_COEFFS);
  localparam int CW     = ppe_pkg::COEF_W;

  ppe_pkg::cfg_t      cfg;
  ppe_pkg::seq_state_t state_r, state_nxt;
  ppe_pkg::req_t      req;

  logic signed [CW-1:0] cmem [CDEPTH];
  logic [31:0]          bmem [BDEPTH];
  logic signed [CW-1:0] c_rdata_r;
  logic [31:0]          b_rdata_r;
  logic [CA_W-1:0]      c_waddr, c_raddr;
  logic [BP_W-1:0]      b_waddr;
  logic                 c_we, b_we;

  logic [31:0]          t_r, prev_r;
  logic [BP_W-1:0]      idx_r, n_r, n_calc;
  logic [SEG_W-1:0]     seg_r;
  logic                 hit_r, match, hit_now;
  logic [K_W-1:0]       k_r, deg_r, deg_calc;
  logic [1:0]           axis_r;
  logic signed [CW-1:0] c_r, ks_r, acc_p_r, acc_d_r, mt_r, mul_src, ks_now;
  logic signed [CW-1:0] dx_r, dy_r;
  logic [CW-1:0]        lo_r, hi_r, src_mag;
  logic                 neg_r;
  logic [31:0]          px_r, py_r, pz_r;
  logic signed [15:0]   hd_r;
  logic                 found_r;

  logic                 out_valid_r;
  logic signed [31:0]   o_x_r, o_y_r, o_z_r;
  logic signed [15:0]   o_hd_r;
  logic                 o_found_r;
  logic                 load_out, in_acc, cordic_start, cordic_done;
  logic signed [15:0]   cordic_hd;

  ppe_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg (cfg)
  );

  ppe_cordic u_cordic (
    .clk, .rst_n,
    .start   (cordic_start),
    .dx      (dx_r),
    .dy      (dy_r),
    .done    (cordic_done),
    .heading (cordic_hd)
  );

  assign req    = ppe_pkg::req_t'(in_ch.req_type);
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    if (int'(cfg.segment_count) > MAX_SEGMENTS) n_calc = BP_W'(MAX_SEGMENTS);
    else n_calc = BP_W'(cfg.segment_count);
    if (int'(cfg.poly_degree) > MAX_COEFFS - 1) deg_calc = K_W'(MAX_COEFFS - 1);
    else deg_calc = K_W'(cfg.poly_degree);
  end

  // Load writes; out-of-range indexes are dropped.
  assign c_we = in_acc && req == ppe_pkg::REQ_COEFF && in_ch.axis <= 2'd2
                && int'(in_ch.slot) < MAX_SEGMENTS && int'(in_ch.coeff_index) < MAX_COEFFS;
  assign b_we = in_acc && req == ppe_pkg::REQ_BREAK && int'(in_ch.slot) <= MAX_SEGMENTS;
  assign c_waddr = CA_W'((int'(in_ch.axis) * MAX_SEGMENTS + int'(in_ch.slot)) * MAX_COEFFS
                         + int'(in_ch.coeff_index));
  assign b_waddr = BP_W'(in_ch.slot);
  assign c_raddr = CA_W'((int'(axis_r) * MAX_SEGMENTS + int'(seg_r)) * MAX_COEFFS
                         + int'(k_r));

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= in_ch.coeff_value;
    c_rdata_r <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= in_ch.time_value;
    b_rdata_r <= bmem[idx_r];
  end

  assign match   = (idx_r != '0) && prev_r <= t_r && t_r <= b_rdata_r;
  assign hit_now = hit_r || match;
  assign ks_now  = ppe_pkg::mul_small(c_rdata_r, 4'(k_r));
  assign mul_src = (state_r == ppe_pkg::ST_CO_LD) ? acc_p_r : acc_d_r;
  assign src_mag = ppe_pkg::mag64(mul_src);
  assign load_out = (state_r == ppe_pkg::ST_RESULT) && (!out_valid_r || out_ch.ready);
  assign cordic_start = (state_r == ppe_pkg::ST_NEXT) && k_r == '0 && axis_r == 2'd2
                        && t_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ppe_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ppe_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && req == ppe_pkg::REQ_EVAL) begin
          state_nxt = (n_calc == '0) ? ppe_pkg::ST_RESULT : ppe_pkg::ST_SRCH_RD;
        end
      end
      ppe_pkg::ST_SRCH_RD: state_nxt = ppe_pkg::ST_SRCH_CMP;
      ppe_pkg::ST_SRCH_CMP: begin
        if (idx_r == n_r) state_nxt = hit_now ? ppe_pkg::ST_CO_RD : ppe_pkg::ST_RESULT;
        else              state_nxt = ppe_pkg::ST_SRCH_RD;
      end
      ppe_pkg::ST_CO_RD: state_nxt = ppe_pkg::ST_CO_LD;
      ppe_pkg::ST_CO_LD: state_nxt = (k_r == deg_r) ? ppe_pkg::ST_NEXT : ppe_pkg::ST_P_FIN;
      ppe_pkg::ST_P_FIN: state_nxt = ppe_pkg::ST_P_ADD;
      ppe_pkg::ST_P_ADD: state_nxt = (k_r != '0) ? ppe_pkg::ST_D_FIN : ppe_pkg::ST_NEXT;
      ppe_pkg::ST_D_FIN: state_nxt = ppe_pkg::ST_D_ADD;
      ppe_pkg::ST_D_ADD: state_nxt = ppe_pkg::ST_NEXT;
      ppe_pkg::ST_NEXT: begin
        if (k_r != '0 || axis_r != 2'd2) state_nxt = ppe_pkg::ST_CO_RD;
        else if (t_r == '0)              state_nxt = ppe_pkg::ST_RESULT;
        else                             state_nxt = ppe_pkg::ST_YAW;
      end
      ppe_pkg::ST_YAW:    if (cordic_done) state_nxt = ppe_pkg::ST_RESULT;
      ppe_pkg::ST_RESULT: if (load_out) state_nxt = ppe_pkg::ST_IDLE;
      default:            state_nxt = ppe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ppe_pkg::ST_IDLE: begin
        t_r     <= in_ch.time_value;
        n_r     <= n_calc;
        deg_r   <= deg_calc;
        idx_r   <= '0;
        hit_r   <= 1'b0;
        found_r <= 1'b0;
        seg_r   <= '0;
        axis_r  <= '0;
      end
      ppe_pkg::ST_SRCH_CMP: begin
        prev_r <= b_rdata_r;
        // The later matching segment wins.
        if (match) begin
          hit_r <= 1'b1;
          seg_r <= SEG_W'(idx_r - 1'b1);
        end
        if (idx_r != n_r) idx_r <= idx_r + 1'b1;
        k_r     <= deg_r;
        found_r <= hit_now;
        hd_r    <= cfg.start_yaw;
      end
      ppe_pkg::ST_CO_LD: begin
        c_r   <= c_rdata_r;
        ks_r  <= ks_now;
        lo_r  <= {32'd0, src_mag[31:0]} * {32'd0, t_r};
        hi_r  <= {32'd0, src_mag[63:32]} * {32'd0, t_r};
        neg_r <= mul_src[CW-1];
        if (k_r == deg_r) begin
          acc_p_r <= c_rdata_r;
          acc_d_r <= ks_now;
        end
      end
      ppe_pkg::ST_P_FIN, ppe_pkg::ST_D_FIN: begin
        mt_r <= ppe_pkg::mul_time_fin(neg_r, lo_r, hi_r);
      end
      ppe_pkg::ST_P_ADD: begin
        acc_p_r <= ppe_pkg::sat_add(mt_r, c_r);
        lo_r    <= {32'd0, src_mag[31:0]} * {32'd0, t_r};
        hi_r    <= {32'd0, src_mag[63:32]} * {32'd0, t_r};
        neg_r   <= mul_src[CW-1];
      end
      ppe_pkg::ST_D_ADD: begin
        acc_d_r <= ppe_pkg::sat_add(mt_r, ks_r);
      end
      ppe_pkg::ST_NEXT: begin
        if (k_r != '0) begin
          k_r <= k_r - 1'b1;
        end else begin
          case (axis_r)
            2'd0: begin
              px_r <= ppe_pkg::to_q16(acc_p_r);
              dx_r <= acc_d_r;
            end
            2'd1: begin
              py_r <= ppe_pkg::to_q16(acc_p_r);
              dy_r <= acc_d_r;
            end
            default: pz_r <= ppe_pkg::to_q16(acc_p_r);
          endcase
          axis_r <= axis_r + 2'd1;
          k_r    <= deg_r;
        end
      end
      ppe_pkg::ST_YAW: begin
        if (cordic_done) hd_r <= cordic_hd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_x_r     <= found_r ? px_r : '0;
      o_y_r     <= found_r ? py_r : '0;
      o_z_r     <= found_r ? pz_r : '0;
      o_hd_r    <= found_r ? hd_r : '0;
      o_found_r <= found_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = o_x_r;
  assign out_ch.pos_y   = o_y_r;
  assign out_ch.pos_z   = o_z_r;
  assign out_ch.heading = o_hd_r;
  assign out_ch.found   = o_found_r;

endmodule
